>>> design/ordered_list_engine_macros.svh
// ----------------------------------------------------------------------------
// ordered_list_engine_macros.svh
// Assertion shorthands for the ordered list engine, sampled on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define OLE_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list engine assertion failed");

// Consequent must hold in the cycle after the antecedent
`define OLE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list engine assertion failed");

`endif

>>> design/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and codes of the ordered list engine: request and result
// transactions, action and status codes, the command broadcast to the cells.
// ----------------------------------------------------------------------------
package olist_pkg;

  // Field widths of the transactions
  localparam int ActionW = 3;
  localparam int ValueW  = 32;
  localparam int PosW    = 8;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // Request actions
  typedef enum logic [ActionW-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_SEARCH    = 3'd6,
    ACT_TRAVERSE  = 3'd7
  } action_e;

  // Result status
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SEARCH,
    CTL_TRAV
  } ctl_state_e;

  // Per-cycle cell operation
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE,
    CELL_COMPARE
  } cell_op_e;

  // Request transaction
  typedef struct packed {
    logic        [ActionW-1:0] action;
    logic signed [ValueW-1:0]  value;
    logic        [PosW-1:0]    position;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic signed [ValueW-1:0]  element;
    logic                      found;
    logic        [StatusW-1:0] status;
    logic        [CountW-1:0]  entry_count;
    logic                      last;
  } out_item_t;

  // Command broadcast along the row of cells
  typedef struct packed {
    cell_op_e                 op;
    logic signed [ValueW-1:0] key;
  } cell_cmd_t;

endpackage

>>> design/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// One storage cell of the list row. Holds one entry and a compare flag, and
// shifts toward its neighbors on insert, delete and traverse rotation.
// ----------------------------------------------------------------------------
module olist_cell #(
  parameter int IdxW    = 4,
  parameter int CellIdx = 0
) (
  input  logic                                   clk_i,
  input  olist_pkg::cell_cmd_t                   cmd_i,
  input  logic        [IdxW-1:0]                 idx_i,
  input  logic        [IdxW-1:0]                 tail_i,
  input  logic signed [olist_pkg::ValueW-1:0]    left_i,
  input  logic signed [olist_pkg::ValueW-1:0]    right_i,
  input  logic signed [olist_pkg::ValueW-1:0]    head_i,
  output logic signed [olist_pkg::ValueW-1:0]    value_o,
  output logic                                   match_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic signed [olist_pkg::ValueW-1:0] value_q, value_d;
  logic                                match_q, match_d;

  // Next entry value and compare flag
  always_comb begin
    value_d = value_q;
    match_d = match_q;
    case (cmd_i.op)
      olist_pkg::CELL_INSERT: begin
        if (MyIdx == idx_i) begin
          value_d = cmd_i.key;
        end else if (MyIdx > idx_i) begin
          value_d = left_i;
        end
      end
      olist_pkg::CELL_DELETE: begin
        if (MyIdx >= idx_i) begin
          value_d = right_i;
        end
      end
      olist_pkg::CELL_ROTATE: begin
        value_d = (MyIdx == tail_i) ? head_i : right_i;
      end
      olist_pkg::CELL_COMPARE: begin
        match_d = (value_q == cmd_i.key);
      end
      default: begin
      end
    endcase
  end

  // Entry storage; payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

>>> design/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to CAPACITY signed 32-bit entries kept in a shifting
// row of cells. Inserts and deletes at front, back or position, searches
// for a value and streams out all entries.
//
//   Channel   Dir  Handshake             Payload
//   in        in   in_valid_i/in_stall_o  olist_pkg::in_item_t
//   out       out  out_valid_o/out_stall_i olist_pkg::out_item_t
//
// Insert and delete: the cells shift in place on the accept edge.
// Search: the cells register compare flags, then they are ORed.
// Traverse: one entry per cycle while the result is not stalled, as the row rotates.
// Reset clears the entry count and controller; entry storage is not reset.
// A stalled result holds the controller; new requests wait until idle.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_macros.svh"

module ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  olist_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output olist_pkg::out_item_t  out_item_o
);

  localparam int CntW    = $clog2(CAPACITY + 1);
  localparam int IdxW    = $clog2(CAPACITY);
  localparam int PosW    = olist_pkg::PosW;
  localparam int CmpW    = ((CntW > PosW) ? CntW : PosW) + 1;
  localparam int OutCntW = olist_pkg::CountW;
  localparam int ValW    = olist_pkg::ValueW;

  // Controller state
  olist_pkg::ctl_state_e state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [IdxW-1:0]       trav_q, trav_d;
  logic                  out_valid_q, out_valid_d;
  olist_pkg::out_item_t  out_item_q, out_item_d;

  // Cell row
  olist_pkg::cell_cmd_t    cmd;
  logic [IdxW-1:0]         idx;
  logic [IdxW-1:0]         tail;
  logic signed [ValW-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0]     match_vec;
  logic [CAPACITY-1:0]     live_vec;

  // Handshake helpers
  logic accept;
  logic out_free;
  logic out_load;
  logic trav_last;
  logic trav_end;

  // Request decode
  logic            pos_zero;
  logic            pos_beyond;
  logic            list_full;
  logic            list_empty;
  logic [IdxW-1:0] pos_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign tail       = IdxW'(count_q - CntW'(1));
  assign trav_last  = (trav_q == tail);
  assign trav_end   = (state_q == olist_pkg::CTL_TRAV) && out_load && trav_last;
  assign pos_zero   = (in_item_i.position == '0);
  assign pos_beyond = (CmpW'(in_item_i.position) > CmpW'(count_q));
  assign list_full  = (count_q >= CntW'(CAPACITY));
  assign list_empty = (count_q == '0);
  assign pos_idx    = IdxW'(in_item_i.position - PosW'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      olist_pkg::CTL_IDLE: begin
        if (accept && in_item_i.action == olist_pkg::ACT_SEARCH) begin
          state_d = olist_pkg::CTL_SEARCH;
        end else if (accept && in_item_i.action == olist_pkg::ACT_TRAVERSE &&
                     !list_empty) begin
          state_d = olist_pkg::CTL_TRAV;
        end
      end
      olist_pkg::CTL_SEARCH: begin
        if (out_free) begin
          state_d = olist_pkg::CTL_IDLE;
        end
      end
      olist_pkg::CTL_TRAV: begin
        if (out_free && trav_last) begin
          state_d = olist_pkg::CTL_IDLE;
        end
      end
      default: begin
        state_d = olist_pkg::CTL_IDLE;
      end
    endcase
  end

  // Outputs of the controller: cell command, count, result register load
  always_comb begin
    in_stall_o = 1'b1;
    cmd.op     = olist_pkg::CELL_HOLD;
    cmd.key    = in_item_i.value;
    idx        = '0;
    count_d    = count_q;
    trav_d     = trav_q;
    out_load   = 1'b0;
    out_item_d = '0;
    out_item_d.last = 1'b1;
    out_item_d.status = olist_pkg::ST_OK;

    unique case (state_q)
      olist_pkg::CTL_IDLE: begin
        in_stall_o = !out_free;
        if (accept) begin
          trav_d = '0;
          unique case (in_item_i.action) inside
            olist_pkg::ACT_INS_FRONT, olist_pkg::ACT_INS_BACK,
            olist_pkg::ACT_INS_AT: begin
              out_load = 1'b1;
              if (in_item_i.action == olist_pkg::ACT_INS_AT && pos_zero) begin
                out_item_d.status = olist_pkg::ST_BADPOS;
              end else if (list_full) begin
                out_item_d.status = olist_pkg::ST_FULL;
              end else begin
                cmd.op  = olist_pkg::CELL_INSERT;
                count_d = count_q + CntW'(1);
                if (in_item_i.action == olist_pkg::ACT_INS_FRONT) begin
                  idx = '0;
                end else if (in_item_i.action == olist_pkg::ACT_INS_BACK ||
                             pos_beyond) begin
                  idx = IdxW'(count_q);
                end else begin
                  idx = pos_idx;
                end
              end
            end
            olist_pkg::ACT_DEL_FRONT, olist_pkg::ACT_DEL_BACK,
            olist_pkg::ACT_DEL_AT: begin
              out_load = 1'b1;
              if (in_item_i.action == olist_pkg::ACT_DEL_AT && pos_zero) begin
                out_item_d.status = olist_pkg::ST_BADPOS;
              end else if (list_empty) begin
                out_item_d.status = olist_pkg::ST_EMPTY;
              end else if (in_item_i.action == olist_pkg::ACT_DEL_AT &&
                           pos_beyond) begin
                out_item_d.status = olist_pkg::ST_BADPOS;
              end else begin
                cmd.op  = olist_pkg::CELL_DELETE;
                count_d = count_q - CntW'(1);
                if (in_item_i.action == olist_pkg::ACT_DEL_FRONT) begin
                  idx = '0;
                end else if (in_item_i.action == olist_pkg::ACT_DEL_BACK) begin
                  idx = tail;
                end else begin
                  idx = pos_idx;
                end
              end
            end
            olist_pkg::ACT_SEARCH: begin
              cmd.op = olist_pkg::CELL_COMPARE;
            end
            default: begin
              // Traverse of an empty list answers at once
              if (list_empty) begin
                out_load = 1'b1;
                out_item_d.status = olist_pkg::ST_EMPTY;
              end
            end
          endcase
          out_item_d.entry_count = OutCntW'(count_d);
        end
      end
      olist_pkg::CTL_SEARCH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_item_d.found = |(match_vec & live_vec);
          out_item_d.entry_count = OutCntW'(count_q);
        end
      end
      olist_pkg::CTL_TRAV: begin
        if (out_free) begin
          out_load = 1'b1;
          cmd.op   = olist_pkg::CELL_ROTATE;
          trav_d   = trav_q + IdxW'(1);
          out_item_d.element     = cell_val[0];
          out_item_d.entry_count = OutCntW'(count_q);
          out_item_d.last        = trav_last;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::CTL_IDLE;
      count_q     <= '0;
      trav_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      trav_q      <= trav_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] left;
    logic signed [ValW-1:0] right;

    if (i == 0) begin : g_first
      assign left = cell_val[0];
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right = cell_val[i];
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end

    assign live_vec[i] = (CntW'(i) < count_q);

    olist_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (idx),
      .tail_i  (tail),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_val[0]),
      .value_o (cell_val[i]),
      .match_o (match_vec[i])
    );
  end

  // Checks
  `OLE_ASSERT_SAME(a_count_range, 1'b1, count_q <= CntW'(CAPACITY))
  `OLE_ASSERT_SAME(a_accept_idle, accept, state_q == olist_pkg::CTL_IDLE)
  `OLE_ASSERT_NEXT(a_trav_done, trav_end, state_q == olist_pkg::CTL_IDLE)
  `OLE_ASSERT_NEXT(a_count_hold, !accept, $stable(count_q))

endmodule
